@@ design/cg_hsb_pkg.sv @@
`default_nettype none

package cg_hsb_pkg;

  typedef struct packed {
    logic signed [15:0] hue_in;
    logic signed [15:0] density_in;
    logic signed [15:0] saturation_in;
    logic signed [15:0] exposure_in;
  } in_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } out_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  localparam logic [12:0]        HUE_MAX      = 13'd5760;
  localparam logic [13:0]        HALF_TURN    = 14'd2880;
  localparam logic [9:0]         DEG_TURN     = 10'd360;
  localparam logic [9:0]         SECTOR_UNITS = 10'd960;
  localparam logic signed [11:0] SLIDER_LIM   = 12'sd1600;
  localparam logic [22:0]        V_BIAS       = 23'd5120000;
  localparam logic [23:0]        SEC_DEN      = 24'd15728640;
  localparam logic [14:0]        Q14_ONE      = 15'd16384;
  localparam logic [22:0]        RECIP_625    = 23'd6871947;
  localparam logic [27:0]        RECIP_25     = 28'd171798691;
  localparam logic [20:0]        RECIP_15     = 21'd1118481;

  function automatic logic signed [11:0] clamp_slider(input logic signed [15:0] x);
    logic signed [11:0] r;
    if (x < -16'sd1600) begin
      r = -SLIDER_LIM;
    end else if (x > 16'sd1600) begin
      r = SLIDER_LIM;
    end else begin
      r = x[11:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/color_grading_hsb_to_rgba_top.sv @@
`default_nettype none

// Converts one colour-grading band (hue, density, saturation, exposure in 1/16 units) per
// transfer into doubled RGB and alpha in Q2.14. The datapath is a seven-stage register
// pipeline, and a new band can enter in every cycle unless a stalled output holds the
// pipeline back; the stages hold the constant divisions (reciprocal multiply, then a
// correction step) and the hue-fraction products that lie between those divisions. Stages
// with no valid band are filled while the output is stalled.
module color_grading_hsb_to_rgba_top
  import cg_hsb_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  wire in_t in_data_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned NumStages = 7;

  localparam logic [12:0] SB1 = 13'd960;
  localparam logic [12:0] SB2 = 13'd1920;
  localparam logic [12:0] SB3 = 13'd2880;
  localparam logic [12:0] SB4 = 13'd3840;
  localparam logic [12:0] SB5 = 13'd4800;

  logic [NumStages:1] vld_q;
  logic [NumStages:1] rdy;

  always_comb begin
    rdy[NumStages] = !vld_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: clamping, hue turn for negative density, sector split and squares.
  logic [12:0]        h_c;
  logic signed [11:0] d_c, sat_c, e_c;
  logic [11:0]        d_neg, e_neg;
  logic [10:0]        dmag, emag;
  logic [13:0]        hsum;
  logic [9:0]         deg, deg_w;
  logic [12:0]        h_sel, hu, base;
  sector_e            sec;
  logic [21:0]        dsq, esq;
  logic [22:0]        xs, xv;
  logic signed [12:0] sa;
  logic [19:0]        xa;

  always_comb begin
    if (in_data_i.hue_in < 16'sd0) begin
      h_c = '0;
    end else if (in_data_i.hue_in > 16'sd5760) begin
      h_c = HUE_MAX;
    end else begin
      h_c = in_data_i.hue_in[12:0];
    end
    d_c   = clamp_slider(in_data_i.density_in);
    sat_c = clamp_slider(in_data_i.saturation_in);
    e_c   = clamp_slider(in_data_i.exposure_in);

    d_neg = 12'(-d_c);
    e_neg = 12'(-e_c);
    dmag  = d_c[11] ? d_neg[10:0] : d_c[10:0];
    emag  = e_c[11] ? e_neg[10:0] : e_c[10:0];

    hsum  = {1'b0, h_c} + HALF_TURN;
    deg   = hsum[13:4];
    deg_w = (deg >= DEG_TURN) ? deg - DEG_TURN : deg;
    h_sel = d_c[11] ? {deg_w[8:0], 4'b0000} : h_c;
    hu    = (h_sel >= HUE_MAX) ? '0 : h_sel;

    if (hu < SB1) begin
      sec  = SEC_RED_YEL;
      base = '0;
    end else if (hu < SB2) begin
      sec  = SEC_YEL_GRN;
      base = SB1;
    end else if (hu < SB3) begin
      sec  = SEC_GRN_CYN;
      base = SB2;
    end else if (hu < SB4) begin
      sec  = SEC_CYN_BLU;
      base = SB3;
    end else if (hu < SB5) begin
      sec  = SEC_BLU_MAG;
      base = SB4;
    end else begin
      sec  = SEC_MAG_RED;
      base = SB5;
    end

    dsq = dmag * dmag;
    esq = emag * emag;
    xs  = {dsq, 1'b0};
    xv  = e_c[11] ? V_BIAS - {1'b0, esq} : V_BIAS + {1'b0, esq};
    sa  = {sat_c[11], sat_c} + 13'sd1600;
    xa  = {sa[11:0], 8'h00};
  end

  sector_e     a_sec_q;
  logic [9:0]  a_m_q;
  logic [22:0] a_xs_q, a_xv_q;
  logic [19:0] a_xa_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      a_sec_q <= sec;
      a_m_q   <= 10'(hu - base);
      a_xs_q  <= xs;
      a_xv_q  <= xv;
      a_xa_q  <= xa;
    end
  end

  // Stage 2: reciprocal estimates of the divisions by 625 and by 25.
  logic [45:0] ps, pv;
  logic [47:0] pa;

  assign ps = a_xs_q * RECIP_625;
  assign pv = a_xv_q * RECIP_625;
  assign pa = a_xa_q * RECIP_25;

  sector_e     b_sec_q;
  logic [9:0]  b_m_q;
  logic [22:0] b_xs_q, b_xv_q;
  logic [19:0] b_xa_q;
  logic [13:0] b_qs_q, b_qv_q;
  logic [15:0] b_qa_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      b_sec_q <= a_sec_q;
      b_m_q   <= a_m_q;
      b_xs_q  <= a_xs_q;
      b_xv_q  <= a_xv_q;
      b_xa_q  <= a_xa_q;
      b_qs_q  <= ps[45:32];
      b_qv_q  <= pv[45:32];
      b_qa_q  <= pa[47:32];
    end
  end

  // Stage 3: one correction step gives the exact quotients.
  logic [23:0] rs, rv;
  logic [19:0] ra;

  assign rs = {1'b0, b_xs_q} - b_qs_q * 24'd625;
  assign rv = {1'b0, b_xv_q} - b_qv_q * 24'd625;
  assign ra = b_xa_q - b_qa_q * 20'd25;

  sector_e     c_sec_q;
  logic [9:0]  c_m_q;
  logic [13:0] c_s_q, c_v_q;
  logic [15:0] c_alpha_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      c_sec_q   <= b_sec_q;
      c_m_q     <= b_m_q;
      c_s_q     <= (rs >= 24'd625) ? b_qs_q + 14'd1 : b_qs_q;
      c_v_q     <= (rv >= 24'd625) ? b_qv_q + 14'd1 : b_qv_q;
      c_alpha_q <= (ra >= 20'd25) ? b_qa_q + 16'd1 : b_qa_q;
    end
  end

  // Stage 4: saturation times hue fraction, and the p term.
  logic [9:0]  nm;
  logic [23:0] sm, st;
  logic [14:0] ns;
  logic [28:0] pp;

  assign nm = SECTOR_UNITS - c_m_q;
  assign sm = c_s_q * c_m_q;
  assign st = c_s_q * nm;
  assign ns = Q14_ONE - {1'b0, c_s_q};
  assign pp = c_v_q * ns;

  sector_e     d_sec_q;
  logic [23:0] d_aq_q, d_at_q;
  logic [15:0] d_p_q, d_alpha_q;
  logic [13:0] d_v_q;
  logic        d_grey_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      d_sec_q   <= c_sec_q;
      d_aq_q    <= SEC_DEN - sm;
      d_at_q    <= SEC_DEN - st;
      d_p_q     <= pp[28:13];
      d_v_q     <= c_v_q;
      d_grey_q  <= (c_s_q == '0);
      d_alpha_q <= c_alpha_q;
    end
  end

  // Stage 5: brightness times the q and t factors, scaled down by 2^19.
  logic [37:0] yq, yt;

  assign yq = d_v_q * d_aq_q;
  assign yt = d_v_q * d_at_q;

  sector_e     e_sec_q;
  logic [18:0] e_yq_q, e_yt_q;
  logic [15:0] e_p_q, e_alpha_q;
  logic [13:0] e_v_q;
  logic        e_grey_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      e_sec_q   <= d_sec_q;
      e_yq_q    <= yq[37:19];
      e_yt_q    <= yt[37:19];
      e_p_q     <= d_p_q;
      e_v_q     <= d_v_q;
      e_grey_q  <= d_grey_q;
      e_alpha_q <= d_alpha_q;
    end
  end

  // Stage 6: reciprocal estimates of the division by 15.
  logic [39:0] zq, zt;

  assign zq = e_yq_q * RECIP_15;
  assign zt = e_yt_q * RECIP_15;

  sector_e     f_sec_q;
  logic [18:0] f_yq_q, f_yt_q;
  logic [15:0] f_q0_q, f_t0_q, f_p_q, f_alpha_q;
  logic [13:0] f_v_q;
  logic        f_grey_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      f_sec_q   <= e_sec_q;
      f_yq_q    <= e_yq_q;
      f_yt_q    <= e_yt_q;
      f_q0_q    <= zq[39:24];
      f_t0_q    <= zt[39:24];
      f_p_q     <= e_p_q;
      f_v_q     <= e_v_q;
      f_grey_q  <= e_grey_q;
      f_alpha_q <= e_alpha_q;
    end
  end

  // Stage 7: correction step and sector selection into the output register.
  logic [18:0] rq, rt;
  logic [15:0] qv, tv, pv2, vv;
  out_t        res;

  always_comb begin
    rq  = f_yq_q - f_q0_q * 19'd15;
    rt  = f_yt_q - f_t0_q * 19'd15;
    qv  = (rq >= 19'd15) ? f_q0_q + 16'd1 : f_q0_q;
    tv  = (rt >= 19'd15) ? f_t0_q + 16'd1 : f_t0_q;
    pv2 = f_p_q;
    vv  = {1'b0, f_v_q, 1'b0};
    res.alpha = f_alpha_q;
    if (f_grey_q) begin
      res.red   = vv;
      res.green = vv;
      res.blue  = vv;
    end else begin
      case (f_sec_q)
        SEC_RED_YEL: begin
          res.red = vv;  res.green = tv;  res.blue = pv2;
        end
        SEC_YEL_GRN: begin
          res.red = qv;  res.green = vv;  res.blue = pv2;
        end
        SEC_GRN_CYN: begin
          res.red = pv2; res.green = vv;  res.blue = tv;
        end
        SEC_CYN_BLU: begin
          res.red = pv2; res.green = qv;  res.blue = vv;
        end
        SEC_BLU_MAG: begin
          res.red = tv;  res.green = pv2; res.blue = vv;
        end
        default: begin
          res.red = vv;  res.green = pv2; res.blue = qv;
        end
      endcase
    end
  end

  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      out_q <= res;
    end
  end

  assign out_valid_o = vld_q[NumStages];
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_empty_first_stage_no_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !vld_q[1] |-> !in_stall_o)
    else $error("input stalled although the first stage is empty");

  a_hsb_ranges: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (c_v_q >= 14'd4096) && (c_v_q <= 14'd12288) && (c_s_q <= 14'd8192))
    else $error("brightness or saturation out of range after division");

  a_channels_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.red <= 16'd24576) && (out_data_o.green <= 16'd24576)
                    && (out_data_o.blue <= 16'd24576))
    else $error("colour channel exceeds twice full brightness");

  a_alpha_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> out_data_o.alpha <= 16'd32768)
    else $error("alpha out of range");
`endif

endmodule

`default_nettype wire
